>>> rtl/ips_pkg.sv
// shared types, constants and arithmetic helpers for the injector pulse stretcher
`timescale 1ns / 1ps

package ips_pkg;

  // stream word layout
  localparam int NOW_W       = 48;
  localparam int LINE_W      = 5;
  localparam int IN_TDATA_W  = 56;
  localparam int FACTOR_W    = 8;
  localparam int OUT_W       = LINE_W + FACTOR_W + 1;
  localparam int OUT_TDATA_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_FACTOR   = 3'd0,
    REG_TEMPERATURE   = 3'd1,
    REG_COLD_GAIN     = 3'd2,
    REG_DECAY         = 3'd3,
    REG_STALL_TIMEOUT = 3'd4,
    REG_RUN_CONFIRM   = 3'd5
  } cfg_reg_e;

  // factor arithmetic
  localparam int COLD_REF_TENTHS = 450;
  localparam int FACTOR_CAP      = 170;
  localparam int FACTOR_RESET    = 100;
  localparam int PCT_SCALE       = 100;
  localparam int FMUL_W          = 9;   // width of 100 + factor

  // seconds since running, saturated just above any possible factor spread
  localparam int US_PER_S    = 1000000;
  localparam int SECS_W      = 8;
  localparam int SECS_CAP    = 171;
  localparam int SECS_CAP_US = SECS_CAP * US_PER_S;
  localparam int SECS_PRE    = 6;        // 10^6 = 2^6 * 15625
  localparam int SECS_IN_W   = 22;       // bits of the shifted difference below the cap
  localparam int SECS_SHIFT  = 36;
  localparam logic [22:0] SECS_MUL = 23'd4398047;   // ceil(2^36 / 15625)

  // reciprocal constants
  localparam logic [15:0] DIV100_MUL = 16'd41944;   // ceil(2^22 / 100)
  localparam int          DIV100_SH  = 22;
  localparam logic [15:0] DIV10_MUL  = 16'd52429;   // ceil(2^19 / 10)
  localparam int          DIV10_SH   = 19;

  // what each lane reports to the merge
  typedef struct packed {
    logic low;     // line pulled low in this word
    logic pulse;   // new falling edge in this word
  } lane_flags_t;

  // one byte step of a long division by 100
  typedef struct packed {
    logic [7:0] quo;
    logic [6:0] rem;
  } div100_t;

  function automatic div100_t div100_step(input logic [6:0] rem_in, input logic [7:0] dig);
    logic [14:0] val;
    logic [30:0] prod;
    logic [14:0] back;
    div100_t     res;
    val     = {rem_in, dig};
    prod    = 31'(val) * 31'(DIV100_MUL);
    res.quo = prod[DIV100_SH +: 8];
    back    = 15'(res.quo) * 15'(PCT_SCALE);
    res.rem = 7'(val - back);
    return res;
  endfunction

  // base plus cold-start enrichment, capped
  function automatic logic [FACTOR_W-1:0] cold_start_pct(input logic [5:0] base,
                                                         input logic signed [10:0] temp,
                                                         input logic [3:0] gain);
    logic signed [11:0] diff;
    logic [14:0]        prod;
    logic [33:0]        scaled;
    logic [11:0]        sum;
    diff   = 12'(COLD_REF_TENTHS) - 12'(temp);
    prod   = '0;
    if (diff > 12'sd0) begin
      prod = 15'(diff[10:0]) * 15'(gain);
    end
    scaled = 34'(prod) * 34'(DIV10_MUL);
    sum    = 12'(base) + scaled[DIV10_SH +: 12];
    if (sum > 12'(FACTOR_CAP)) begin
      sum = 12'(FACTOR_CAP);
    end
    return sum[FACTOR_W-1:0];
  endfunction

endpackage

>>> rtl/ips_lane.sv
// one injector lane: edge tracking, stretched hold time and output drive
`timescale 1ns / 1ps

module ips_lane import ips_pkg::*; #(
  parameter int TIME_BITS  = 48,
  parameter int DIV_STAGES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [DIV_STAGES+5:1]    adv_i,
  input  logic [TIME_BITS-1:0]     now_i,
  input  logic                     level_i,
  input  logic [FACTOR_W-1:0]      factor_i,
  output lane_flags_t              flags_o,
  output logic                     drive_o
);

  localparam int NS     = DIV_STAGES + 5;
  localparam int WORD_W = DIV_STAGES * 8;
  localparam int PROD_W = TIME_BITS + FMUL_W;

  // lane state
  logic                 open_q;
  logic [TIME_BITS-1:0] open_stamp_q;
  logic [TIME_BITS-1:0] close_stamp_q;
  logic [TIME_BITS-1:0] hold_q;
  logic                 drive_q;

  // carried per word
  logic                 pl_low_q [1:NS-1];
  logic                 pl_jc_q  [1:NS-1];
  logic [TIME_BITS-1:0] pl_dc_q  [1:NS-1];
  logic [TIME_BITS-1:0] pt_q     [1:3];

  // division chain
  logic [WORD_W-1:0]    dw_q [0:DIV_STAGES];
  logic [6:0]           dr_q [1:DIV_STAGES];

  logic                 low;
  logic                 jc;
  logic [FMUL_W-1:0]    fmul;
  logic [WORD_W-1:0]    hold_full;
  logic [TIME_BITS-1:0] hold_sat;

  // edge decode on the incoming word
  assign low           = ~level_i;
  assign jc            = level_i & open_q;
  assign flags_o.low   = low;
  assign flags_o.pulse = low & ~open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= 1'b0;
      open_stamp_q  <= '0;
      close_stamp_q <= '0;
    end else if (adv_i[1]) begin
      if (low) begin
        open_q <= 1'b1;
        if (!open_q) begin
          open_stamp_q <= now_i;
        end
      end else if (open_q) begin
        open_q        <= 1'b0;
        close_stamp_q <= now_i;
      end
    end
  end

  // first stage of the lane pipeline
  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      pl_low_q[1] <= low;
      pl_jc_q[1]  <= jc;
      pl_dc_q[1]  <= now_i - close_stamp_q;
      pt_q[1]     <= now_i - open_stamp_q;
    end
  end

  // carry the flags and close distance down the pipe
  for (genvar s = 2; s <= NS - 1; s++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (adv_i[s]) begin
        pl_low_q[s] <= pl_low_q[s-1];
        pl_jc_q[s]  <= pl_jc_q[s-1];
        pl_dc_q[s]  <= pl_dc_q[s-1];
      end
    end
  end

  for (genvar s = 2; s <= 3; s++) begin : g_open_time
    always_ff @(posedge clk_i) begin
      if (adv_i[s]) begin
        pt_q[s] <= pt_q[s-1];
      end
    end
  end

  // open time times (100 + factor)
  assign fmul = FMUL_W'(PCT_SCALE) + FMUL_W'(factor_i);

  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      dw_q[0] <= WORD_W'(PROD_W'(pt_q[3]) * PROD_W'(fmul));
    end
  end

  // divide by 100, one byte per stage, quotient shifted in from the bottom
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    div100_t step;
    if (k == 1) begin : g_first
      assign step = div100_step(7'd0, dw_q[k-1][WORD_W-1 -: 8]);
    end else begin : g_next
      assign step = div100_step(dr_q[k-1], dw_q[k-1][WORD_W-1 -: 8]);
    end
    always_ff @(posedge clk_i) begin
      if (adv_i[4+k]) begin
        dw_q[k] <= {dw_q[k-1][WORD_W-9:0], step.quo};
        dr_q[k] <= step.rem;
      end
    end
  end

  // saturate the stretched time
  assign hold_full = dw_q[DIV_STAGES];
  assign hold_sat  = (|hold_full[WORD_W-1:TIME_BITS]) ? '1 : hold_full[TIME_BITS-1:0];

  // output drive, evaluated in word order with the latest hold time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= 1'b0;
      hold_q  <= '0;
    end else if (adv_i[NS]) begin
      if (pl_jc_q[NS-1]) begin
        drive_q <= 1'b1;
        hold_q  <= hold_sat;
      end else if (pl_low_q[NS-1]) begin
        drive_q <= 1'b1;
      end else if (pl_dc_q[NS-1] > hold_q) begin
        drive_q <= 1'b0;
      end
    end
  end

  assign drive_o = drive_q;

endmodule

>>> rtl/ips_ctrl.sv
// shared control: registers, lane merge, start detection and factor decay
`timescale 1ns / 1ps

module ips_ctrl import ips_pkg::*; #(
  parameter int NUM_INJECTORS = 5,
  parameter int TIME_BITS     = 48,
  parameter int DIV_STAGES    = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                 cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                cfg_data_i,
  input  logic [DIV_STAGES+5:1]                adv_i,
  input  logic [TIME_BITS-1:0]                 now_i,
  input  lane_flags_t [NUM_INJECTORS-1:0]      flags_i,
  output logic [FACTOR_W-1:0]                  factor_s3_o,
  output logic [FACTOR_W-1:0]                  factor_o,
  output logic                                 running_o
);

  localparam int NS = DIV_STAGES + 5;

  localparam logic [5:0]         BASE_RESET    = 6'd10;
  localparam logic signed [10:0] TEMP_RESET    = 11'sd150;
  localparam logic [3:0]         GAIN_RESET    = 4'd3;
  localparam logic [3:0]         DECAY_RESET   = 4'd4;
  localparam logic [19:0]        STALL_RESET   = 20'd190000;
  localparam logic [23:0]        CONFIRM_RESET = 24'd2000000;
  localparam logic [TIME_BITS-1:0] SECS_LIMIT  = TIME_BITS'(SECS_CAP_US);

  // configuration registers
  logic [5:0]         base_q;
  logic signed [10:0] temp_q;
  logic [3:0]         gain_q;
  logic [3:0]         decay_q;
  logic [19:0]        stall_q;
  logic [23:0]        confirm_q;
  logic [FACTOR_W-1:0] start_q;

  // start detection state
  logic                 run_q, run_d;
  logic                 fv_q, fv_d;
  logic [TIME_BITS-1:0] first_q, first_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [TIME_BITS-1:0] rs_q, rs_d;

  // pipeline
  logic                 c1_run_pre_q, c1_run_post_q;
  logic [TIME_BITS-1:0] c1_sdiff_q;
  logic                 c2_run_pre_q, c2_run_post_q;
  logic [SECS_W-1:0]    c2_secs_q;
  logic [FACTOR_W-1:0]  fac_q, fac_d;
  logic                 c3_run_post_q;
  logic [FACTOR_W-1:0]  fac_pipe_q [4:NS];
  logic                 run_pipe_q [4:NS];

  logic                 any_low, any_pulse;
  logic                 chk, stall_hit, confirm_hit, fv_mid;
  logic [TIME_BITS-1:0] first_mid;
  logic [44:0]          secs_prod;
  logic [SECS_W-1:0]    secs;
  logic [11:0]          dec;
  logic [FACTOR_W-1:0]  base8, spread;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BASE_RESET;
      temp_q    <= TEMP_RESET;
      gain_q    <= GAIN_RESET;
      decay_q   <= DECAY_RESET;
      stall_q   <= STALL_RESET;
      confirm_q <= CONFIRM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BASE_FACTOR:   base_q    <= cfg_data_i[5:0];
        REG_TEMPERATURE:   temp_q    <= signed'(cfg_data_i[10:0]);
        REG_COLD_GAIN:     gain_q    <= cfg_data_i[3:0];
        REG_DECAY:         decay_q   <= cfg_data_i[3:0];
        REG_STALL_TIMEOUT: stall_q   <= cfg_data_i[19:0];
        REG_RUN_CONFIRM:   confirm_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // start factor follows the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= FACTOR_W'(FACTOR_RESET);
    end else begin
      start_q <= cold_start_pct(base_q, temp_q, gain_q);
    end
  end

  // merge of the lane findings
  always_comb begin
    any_low   = 1'b0;
    any_pulse = 1'b0;
    for (int i = 0; i < NUM_INJECTORS; i++) begin
      any_low   = any_low | flags_i[i].low;
      any_pulse = any_pulse | flags_i[i].pulse;
    end
  end

  // stall and run confirmation on the incoming word
  always_comb begin
    chk         = fv_q & ~run_q;
    stall_hit   = chk & ((now_i - last_q) > TIME_BITS'(stall_q));
    confirm_hit = chk & ~stall_hit & ((now_i - first_q) > TIME_BITS'(confirm_q));
    run_d       = run_q | confirm_hit;
    rs_d        = confirm_hit ? now_i : rs_q;
    fv_mid      = fv_q & ~stall_hit;
    first_mid   = stall_hit ? '0 : first_q;
    fv_d        = fv_mid | any_low;
    first_d     = (any_low & ~fv_mid) ? now_i : first_mid;
    last_d      = any_pulse ? now_i : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      fv_q    <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
      rs_q    <= '0;
    end else if (adv_i[1]) begin
      run_q   <= run_d;
      fv_q    <= fv_d;
      first_q <= first_d;
      last_q  <= last_d;
      rs_q    <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      c1_run_pre_q  <= run_q;
      c1_run_post_q <= run_d;
      c1_sdiff_q    <= now_i - rs_q;
    end
  end

  // whole seconds since running, saturated
  assign secs_prod = 45'(c1_sdiff_q[SECS_PRE +: SECS_IN_W]) * 45'(SECS_MUL);
  assign secs      = (c1_sdiff_q >= SECS_LIMIT) ? SECS_W'(SECS_CAP)
                                                : secs_prod[SECS_SHIFT +: SECS_W];

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      c2_run_pre_q  <= c1_run_pre_q;
      c2_run_post_q <= c1_run_post_q;
      c2_secs_q     <= secs;
    end
  end

  // factor decay towards the base
  assign dec    = 12'(c2_secs_q) * 12'(decay_q);
  assign base8  = FACTOR_W'(base_q);
  assign spread = start_q - base8;

  always_comb begin
    fac_d = start_q;
    if (c2_run_pre_q) begin
      if (fac_q > base8) begin
        if (dec >= 12'(spread)) begin
          fac_d = base8;
        end else begin
          fac_d = start_q - FACTOR_W'(dec);
        end
      end else begin
        fac_d = fac_q;
      end
    end
    if (fac_d < base8) begin
      fac_d = base8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fac_q <= FACTOR_W'(FACTOR_RESET);
    end else if (adv_i[3]) begin
      fac_q <= fac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      c3_run_post_q <= c2_run_post_q;
    end
  end

  // factor and run flag travel beside the lane division
  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      fac_pipe_q[4] <= fac_q;
      run_pipe_q[4] <= c3_run_post_q;
    end
  end

  for (genvar s = 5; s <= NS; s++) begin : g_pipe
    always_ff @(posedge clk_i) begin
      if (adv_i[s]) begin
        fac_pipe_q[s] <= fac_pipe_q[s-1];
        run_pipe_q[s] <= run_pipe_q[s-1];
      end
    end
  end

  assign factor_s3_o = fac_q;
  assign factor_o    = fac_pipe_q[NS];
  assign running_o   = run_pipe_q[NS];

  // once running, always running
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_q |=> run_q)
    else $error("running flag cleared");

  // running only after a first pulse was seen
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(run_q) |-> $past(fv_q))
    else $error("running without first pulse");

  // start detection is dropped only by a stall, which clears the first stamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $fell(fv_q) |-> !run_q && (first_q == '0))
    else $error("first pulse dropped wrongly");

  // factor never above the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni) fac_q <= FACTOR_W'(FACTOR_CAP))
    else $error("factor above cap");

endmodule

>>> rtl/injector_pulse_stretcher.sv
// injector pulse stretcher top level: one word in and one word out per cycle while the output is not held
// path: edge stamps and open time, product, divide-by-100 chain, then output drive
// throughput: one word per cycle while the output is not held; depth set by the divide-by-100 chain, one byte per stage
// reset: asynchronous, active low; lines closed, outputs off, registers at defaults
`timescale 1ns / 1ps

module injector_pulse_stretcher import ips_pkg::*; #(
  parameter int NUM_INJECTORS = 5,
  parameter int TIME_BITS     = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // now_us[47:0], line_levels[52:48], zero pad
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // drive_mask[4:0], factor_pct[12:5],
                                                 // running[13], zero pad
);

  localparam int PROD_W     = TIME_BITS + FMUL_W;
  localparam int DIV_STAGES = (PROD_W + 7) / 8;
  localparam int NS         = DIV_STAGES + 5;

  logic [NS:1]                    v_q;
  logic [NS:1]                    mv;
  logic [NS:1]                    in_v;
  logic [NS:1]                    adv;
  logic [TIME_BITS-1:0]           now;
  lane_flags_t [NUM_INJECTORS-1:0] flags;
  logic [NUM_INJECTORS-1:0]       drive;
  logic [LINE_W-1:0]              mask;
  logic [FACTOR_W-1:0]            factor_s3;
  logic [FACTOR_W-1:0]            factor;
  logic                           running;

  // a stage moves unless it and every stage after it are full and the output is held
  for (genvar g = 1; g <= NS; g++) begin : g_flow
    if (g == 1) begin : g_head
      assign in_v[g] = s_axis_tvalid;
    end else begin : g_body
      assign in_v[g] = v_q[g-1];
    end
    assign mv[g]  = m_axis_tready | ~(&v_q[NS:g]);
    assign adv[g] = in_v[g] & mv[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 1; s <= NS; s++) begin
        if (mv[s]) begin
          v_q[s] <= in_v[s];
        end
      end
    end
  end

  assign s_axis_tready = mv[1];
  assign now           = TIME_BITS'(s_axis_tdata[NOW_W-1:0]);

  // injector lanes
  for (genvar i = 0; i < NUM_INJECTORS; i++) begin : g_lane
    logic level;
    if (i < LINE_W) begin : g_line
      assign level = s_axis_tdata[NOW_W + i];
    end else begin : g_idle
      assign level = 1'b1;
    end
    ips_lane #(
      .TIME_BITS  (TIME_BITS),
      .DIV_STAGES (DIV_STAGES)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .now_i    (now),
      .level_i  (level),
      .factor_i (factor_s3),
      .flags_o  (flags[i]),
      .drive_o  (drive[i])
    );
  end

  // shared control and lane merge
  ips_ctrl #(
    .NUM_INJECTORS (NUM_INJECTORS),
    .TIME_BITS     (TIME_BITS),
    .DIV_STAGES    (DIV_STAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (adv),
    .now_i       (now),
    .flags_i     (flags),
    .factor_s3_o (factor_s3),
    .factor_o    (factor),
    .running_o   (running)
  );

  // drive mask from the lane outputs, missing lanes read as off
  for (genvar i = 0; i < LINE_W; i++) begin : g_mask
    if (i < NUM_INJECTORS) begin : g_on
      assign mask[i] = drive[i];
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tdata  = OUT_TDATA_W'({running, factor, mask});

  // a hole anywhere in the pipe lets a word in
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(&v_q) |-> s_axis_tready)
    else $error("input stalled with room in pipe");

  // a taken result always frees room for a new word
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // an offered result stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before accept");

endmodule
